// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by the alu flag unit top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_RST(name, clk, rst_n, prop)
`define ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ===== hw/rtl/aluf_pkg.sv =====
// types and constants of the alu flag unit
package aluf_pkg;

  typedef enum logic [5:0] {
    OpInc8      = 6'd0,
    OpDec8      = 6'd1,
    OpAdd8      = 6'd2,
    OpSub8      = 6'd3,
    OpAdc8      = 6'd4,
    OpSbc8      = 6'd5,
    OpAdd16     = 6'd6,
    OpOrXor     = 6'd7,
    OpAnd       = 6'd8,
    OpCp        = 6'd9,
    OpAdc16     = 6'd10,
    OpSbc16     = 6'd11,
    OpBlkXfer   = 6'd12,
    OpBlkIo     = 6'd13,
    OpCpd       = 6'd14,
    OpCpi       = 6'd15,
    OpRlca      = 6'd16,
    OpRrca      = 6'd17,
    OpBit       = 6'd18,
    OpRlc       = 6'd19,
    OpRl        = 6'd20,
    OpRrc       = 6'd21,
    OpRr        = 6'd22,
    OpSla       = 6'd23,
    OpSra       = 6'd24,
    OpSll       = 6'd25,
    OpSrl       = 6'd26,
    OpCpl       = 6'd27,
    OpRxd       = 6'd28,
    OpCcf       = 6'd29,
    OpScf       = 6'd30,
    OpRra       = 6'd31,
    OpRla       = 6'd32,
    OpDaa       = 6'd33
  } alu_op_e;

  localparam int unsigned FlagS = 7;
  localparam int unsigned FlagZ = 6;
  localparam int unsigned Flag5 = 5;
  localparam int unsigned FlagH = 4;
  localparam int unsigned Flag3 = 3;
  localparam int unsigned FlagP = 2;
  localparam int unsigned FlagN = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [7:0] FlagsReset = 8'hFF;
  localparam logic [7:0] IncOvfVal  = 8'h7F;
  localparam logic [7:0] DecOvfVal  = 8'h80;
  localparam logic [7:0] DaaHiLimit = 8'h99;
  localparam logic [3:0] DaaLoLimit = 4'h9;
  localparam logic [7:0] DaaLoAdj   = 8'h06;
  localparam logic [7:0] DaaHiAdj   = 8'h60;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [15:0] given_result;
    logic [2:0]  bit_index;
    logic [15:0] counter_in;
    logic [15:0] pointer_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  value_out;
    logic [7:0]  flags_out;
    logic [15:0] counter_out;
    logic [15:0] pointer_out;
  } out_beat_t;

endpackage

// ===== hw/rtl/eight_bit_alu_flag_unit_top.sv =====
// alu flag unit: input register, one compute stage, result register
//
// channel   dir  handshake                 payload
// in        in   in_valid_i / in_ready_o   in_beat_i  (aluf_pkg::in_beat_t)
// out       out  out_valid_o / out_ready_i out_beat_o (aluf_pkg::out_beat_t)
//
// one beat per cycle sustained while out_ready_i stays high; a result passes the input
// register, then the result register
// the rate is set by the flag register loop, closed through the single compute stage
// reset sets the flag register to all ones and empties both registers
// with out_ready_i low the result holds, one more beat waits in the input
// register, then in_ready_o drops
`include "assert_macros.svh"

module eight_bit_alu_flag_unit_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  aluf_pkg::in_beat_t   in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output aluf_pkg::out_beat_t  out_beat_o
);

  logic                in_vld_q;
  aluf_pkg::in_beat_t  in_q;
  logic                out_vld_q;
  aluf_pkg::out_beat_t out_q;
  logic [7:0]          flags_q;
  logic [7:0]          flags_d;
  logic [7:0]          value_d;
  logic [15:0]         cnt_d;
  logic [15:0]         ptr_d;
  logic                advance;

  logic [7:0]  a, b, r8;
  logic [15:0] aw, bw, res;
  logic        cin, c_add, c_sub, c16;
  logic [8:0]  sum9, dif9;
  logic [4:0]  hsum5, hdif5;
  logic [16:0] sum17, dif17;
  logic [12:0] hsum13, hdif13;
  logic [15:0] cnt_dec;
  logic        lo_fix, hi_fix;
  logic [7:0]  corr, daa_r;
  logic [4:0]  daa_h5;
  logic        daa_hc;

  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

  assign a   = in_q.operand_a[7:0];
  assign b   = in_q.operand_b[7:0];
  assign r8  = in_q.given_result[7:0];
  assign aw  = in_q.operand_a;
  assign bw  = in_q.operand_b;
  assign res = in_q.given_result;
  assign cin = flags_q[aluf_pkg::FlagC];

  assign c_add = (in_q.opcode == aluf_pkg::OpAdc8) ? cin : 1'b0;
  assign c_sub = (in_q.opcode == aluf_pkg::OpSbc8) ? cin : 1'b0;
  assign c16   = (in_q.opcode == aluf_pkg::OpAdc16) ? cin : 1'b0;

  assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, c_add};
  assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c_add};
  assign dif9   = {1'b0, a} - {1'b0, b} - {8'd0, c_sub};
  assign hdif5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c_sub};
  assign sum17  = {1'b0, aw} + {1'b0, bw} + {16'd0, c16};
  assign hsum13 = {1'b0, aw[11:0]} + {1'b0, bw[11:0]} + {12'd0, c16};
  assign dif17  = {1'b0, aw} - {1'b0, bw} - {16'd0, cin};
  assign hdif13 = {1'b0, aw[11:0]} - {1'b0, bw[11:0]} - {12'd0, cin};
  assign cnt_dec = in_q.counter_in - 16'd1;

  // decimal adjust
  assign lo_fix = flags_q[aluf_pkg::FlagH] || (a[3:0] > aluf_pkg::DaaLoLimit);
  assign hi_fix = flags_q[aluf_pkg::FlagC] || (a > aluf_pkg::DaaHiLimit);
  assign corr   = (lo_fix ? aluf_pkg::DaaLoAdj : 8'h00) | (hi_fix ? aluf_pkg::DaaHiAdj : 8'h00);
  assign daa_r  = flags_q[aluf_pkg::FlagN] ? (a - corr) : (a + corr);
  assign daa_h5 = {1'b0, a[3:0]} + {1'b0, corr[3:0]};
  assign daa_hc = flags_q[aluf_pkg::FlagN] ? (a[3:0] < corr[3:0]) : daa_h5[4];

  always_comb begin
    flags_d = flags_q;
    value_d = 8'h00;
    cnt_d   = in_q.counter_in;
    ptr_d   = in_q.pointer_in;
    case (in_q.opcode)
      aluf_pkg::OpInc8, aluf_pkg::OpDec8: begin
        flags_d[aluf_pkg::FlagN] = (in_q.opcode == aluf_pkg::OpDec8);
        flags_d[aluf_pkg::FlagS] = r8[7];
        flags_d[aluf_pkg::FlagZ] = (r8 == 8'h00);
        flags_d[aluf_pkg::FlagH] = (in_q.opcode == aluf_pkg::OpInc8) ?
                                   (a[3:0] == 4'hF) : (a[3:0] == 4'h0);
        flags_d[aluf_pkg::FlagP] = (in_q.opcode == aluf_pkg::OpInc8) ?
                                   (a == aluf_pkg::IncOvfVal) : (a == aluf_pkg::DecOvfVal);
        flags_d[aluf_pkg::Flag3] = r8[3];
        flags_d[aluf_pkg::Flag5] = r8[5];
      end
      aluf_pkg::OpAdd8, aluf_pkg::OpAdc8: begin
        flags_d[aluf_pkg::FlagN] = 1'b0;
        flags_d[aluf_pkg::FlagS] = sum9[7];
        flags_d[aluf_pkg::FlagZ] = (sum9[7:0] == 8'h00);
        flags_d[aluf_pkg::FlagH] = hsum5[4];
        flags_d[aluf_pkg::FlagP] = (a[7] ^ sum9[7]) & (b[7] ^ sum9[7]);
        flags_d[aluf_pkg::FlagC] = sum9[8];
        flags_d[aluf_pkg::Flag3] = sum9[3];
        flags_d[aluf_pkg::Flag5] = sum9[5];
        value_d = sum9[7:0];
      end
      aluf_pkg::OpSub8, aluf_pkg::OpSbc8, aluf_pkg::OpCp: begin
        flags_d[aluf_pkg::FlagN] = 1'b1;
        flags_d[aluf_pkg::FlagS] = dif9[7];
        flags_d[aluf_pkg::FlagZ] = (dif9[7:0] == 8'h00);
        flags_d[aluf_pkg::FlagH] = hdif5[4];
        flags_d[aluf_pkg::FlagP] = (a[7] ^ b[7]) & (a[7] ^ dif9[7]);
        flags_d[aluf_pkg::FlagC] = dif9[8];
        flags_d[aluf_pkg::Flag3] = dif9[3];
        flags_d[aluf_pkg::Flag5] = dif9[5];
        value_d = (in_q.opcode == aluf_pkg::OpCp) ? 8'h00 : dif9[7:0];
      end
      aluf_pkg::OpAdd16: begin
        flags_d[aluf_pkg::FlagN] = 1'b0;
        flags_d[aluf_pkg::FlagH] = hsum13[12];
        flags_d[aluf_pkg::FlagC] = sum17[16];
        flags_d[aluf_pkg::Flag3] = res[11];
        flags_d[aluf_pkg::Flag5] = res[13];
      end
      aluf_pkg::OpOrXor, aluf_pkg::OpAnd, aluf_pkg::OpRxd: begin
        flags_d[aluf_pkg::FlagS] = a[7];
        flags_d[aluf_pkg::FlagZ] = (a == 8'h00);
        flags_d[aluf_pkg::FlagN] = 1'b0;
        flags_d[aluf_pkg::FlagP] = ~^a;
        flags_d[aluf_pkg::FlagH] = (in_q.opcode == aluf_pkg::OpAnd);
        if (in_q.opcode != aluf_pkg::OpRxd) begin
          flags_d[aluf_pkg::FlagC] = 1'b0;
          flags_d[aluf_pkg::Flag3] = a[3];
          flags_d[aluf_pkg::Flag5] = a[5];
        end
      end
      aluf_pkg::OpAdc16: begin
        flags_d[aluf_pkg::FlagN] = 1'b0;
        flags_d[aluf_pkg::FlagS] = res[15];
        flags_d[aluf_pkg::FlagZ] = (res == 16'h0000);
        flags_d[aluf_pkg::FlagH] = hsum13[12];
        flags_d[aluf_pkg::FlagP] = (aw[15] ^ res[15]) & (bw[15] ^ res[15]);
        flags_d[aluf_pkg::FlagC] = sum17[16];
        // bits 3 and 5 from the low byte
        flags_d[aluf_pkg::Flag3] = res[3];
        flags_d[aluf_pkg::Flag5] = res[5];
      end
      aluf_pkg::OpSbc16: begin
        flags_d[aluf_pkg::FlagN] = 1'b1;
        flags_d[aluf_pkg::FlagS] = res[15];
        flags_d[aluf_pkg::FlagZ] = (res == 16'h0000);
        flags_d[aluf_pkg::FlagH] = hdif13[12];
        flags_d[aluf_pkg::FlagP] = (aw[15] ^ bw[15]) & (aw[15] ^ res[15]);
        flags_d[aluf_pkg::FlagC] = dif17[16];
        flags_d[aluf_pkg::Flag3] = res[11];
        flags_d[aluf_pkg::Flag5] = res[13];
      end
      aluf_pkg::OpBlkXfer: begin
        flags_d[aluf_pkg::FlagN] = 1'b0;
        flags_d[aluf_pkg::FlagH] = 1'b0;
        flags_d[aluf_pkg::FlagP] = (in_q.counter_in != 16'h0000);
        flags_d[aluf_pkg::Flag3] = in_q.counter_in[11];
        flags_d[aluf_pkg::Flag5] = in_q.counter_in[13];
      end
      aluf_pkg::OpBlkIo: begin
        flags_d[aluf_pkg::FlagZ] = 1'b1;
        flags_d[aluf_pkg::FlagN] = 1'b1;
      end
      aluf_pkg::OpCpd, aluf_pkg::OpCpi: begin
        cnt_d = cnt_dec;
        ptr_d = (in_q.opcode == aluf_pkg::OpCpi) ? (in_q.pointer_in + 16'd1)
                                                 : (in_q.pointer_in - 16'd1);
        flags_d[aluf_pkg::FlagS] = dif9[7];
        flags_d[aluf_pkg::FlagZ] = (dif9[7:0] == 8'h00);
        flags_d[aluf_pkg::FlagH] = hdif5[4];
        flags_d[aluf_pkg::FlagP] = (cnt_dec != 16'h0000);
        flags_d[aluf_pkg::FlagN] = 1'b1;
        value_d = dif9[7:0];
      end
      aluf_pkg::OpRlca, aluf_pkg::OpRrca, aluf_pkg::OpRra, aluf_pkg::OpRla: begin
        flags_d[aluf_pkg::FlagH] = 1'b0;
        flags_d[aluf_pkg::FlagN] = 1'b0;
        case (in_q.opcode)
          aluf_pkg::OpRlca: begin
            value_d = {a[6:0], a[7]};
            flags_d[aluf_pkg::FlagC] = a[7];
          end
          aluf_pkg::OpRrca: begin
            value_d = {a[0], a[7:1]};
            flags_d[aluf_pkg::FlagC] = a[0];
          end
          aluf_pkg::OpRra: begin
            value_d = {cin, a[7:1]};
            flags_d[aluf_pkg::FlagC] = a[0];
          end
          default: begin
            value_d = {a[6:0], cin};
            flags_d[aluf_pkg::FlagC] = a[7];
          end
        endcase
      end
      aluf_pkg::OpBit: begin
        flags_d[aluf_pkg::FlagN] = 1'b0;
        flags_d[aluf_pkg::FlagH] = 1'b1;
        flags_d[aluf_pkg::FlagZ] = !b[in_q.bit_index];
      end
      aluf_pkg::OpRlc, aluf_pkg::OpRl, aluf_pkg::OpRrc, aluf_pkg::OpRr,
      aluf_pkg::OpSla, aluf_pkg::OpSra, aluf_pkg::OpSll, aluf_pkg::OpSrl: begin
        case (in_q.opcode)
          aluf_pkg::OpRlc: value_d = {b[6:0], b[7]};
          aluf_pkg::OpRl:  value_d = {b[6:0], cin};
          aluf_pkg::OpRrc: value_d = {b[0], b[7:1]};
          aluf_pkg::OpRr:  value_d = {cin, b[7:1]};
          aluf_pkg::OpSla: value_d = {b[6:0], 1'b0};
          aluf_pkg::OpSra: value_d = {b[7], b[7:1]};
          aluf_pkg::OpSll: value_d = {b[6:0], 1'b1};
          default:         value_d = {1'b0, b[7:1]};
        endcase
        flags_d[aluf_pkg::FlagS] = value_d[7];
        flags_d[aluf_pkg::FlagZ] = (value_d == 8'h00);
        flags_d[aluf_pkg::FlagH] = 1'b0;
        flags_d[aluf_pkg::FlagN] = 1'b0;
        flags_d[aluf_pkg::FlagP] = ~^value_d;
        case (in_q.opcode)
          aluf_pkg::OpRlc, aluf_pkg::OpRl, aluf_pkg::OpSla, aluf_pkg::OpSll:
            flags_d[aluf_pkg::FlagC] = b[7];
          default:
            flags_d[aluf_pkg::FlagC] = b[0];
        endcase
      end
      aluf_pkg::OpCpl: begin
        flags_d[aluf_pkg::FlagH] = 1'b1;
        flags_d[aluf_pkg::FlagN] = 1'b1;
        value_d = ~a;
      end
      aluf_pkg::OpCcf: begin
        flags_d[aluf_pkg::FlagN] = 1'b0;
        flags_d[aluf_pkg::FlagH] = cin;
        flags_d[aluf_pkg::FlagC] = !cin;
      end
      aluf_pkg::OpScf: begin
        flags_d[aluf_pkg::FlagH] = 1'b0;
        flags_d[aluf_pkg::FlagN] = 1'b0;
        flags_d[aluf_pkg::FlagC] = 1'b1;
      end
      aluf_pkg::OpDaa: begin
        flags_d[aluf_pkg::FlagC] = hi_fix;
        flags_d[aluf_pkg::FlagH] = daa_hc;
        flags_d[aluf_pkg::FlagS] = daa_r[7];
        flags_d[aluf_pkg::FlagZ] = (daa_r == 8'h00);
        flags_d[aluf_pkg::FlagP] = ~^daa_r;
        value_d = daa_r;
      end
      default: begin
        flags_d = flags_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      flags_q   <= aluf_pkg::FlagsReset;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        flags_q   <= flags_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_beat_i;
    end
    if (advance) begin
      out_q.value_out   <= value_d;
      out_q.flags_out   <= flags_d;
      out_q.counter_out <= cnt_d;
      out_q.pointer_out <= ptr_d;
    end
  end

  `ASSERT_RST(a_flags_match_out, clk_i, rst_ni, out_vld_q |-> out_q.flags_out == flags_q)
  `ASSERT_RST(a_stage_holds, clk_i, rst_ni, (in_vld_q && !advance) |=> (in_vld_q && $stable(in_q)))
  `ASSERT_RST(a_advance_fills, clk_i, rst_ni, advance |=> out_vld_q)
  `ASSERT_RST(a_unused_op, clk_i, rst_ni, (advance && in_q.opcode > aluf_pkg::OpDaa) |=> (out_q.value_out == 8'h00 && out_q.flags_out == $past(flags_q)))
  `ASSERT_RST(a_cnt_pass, clk_i, rst_ni, (advance && in_q.opcode != aluf_pkg::OpCpd && in_q.opcode != aluf_pkg::OpCpi) |=> out_q.counter_out == $past(in_q.counter_in))

endmodule

// ===== bench/tb_top.sv =====
// testbench for the alu flag unit: predicted value, flags, counter and pointer checked on every output beat
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned HoldCycles = 64;
  localparam logic [5:0] OpUnusedLo = 6'd34;
  localparam logic [5:0] OpUnusedHi = 6'd63;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  aluf_pkg::in_beat_t in_beat_i;
  logic out_valid_o;
  logic out_ready_i;
  aluf_pkg::out_beat_t out_beat_o;

  logic [7:0] flag_model = aluf_pkg::FlagsReset;
  aluf_pkg::out_beat_t alu_results_due[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;

  eight_bit_alu_flag_unit_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [7:0] with_x53(logic [7:0] f, logic [7:0] r);
    f[aluf_pkg::Flag3] = r[3];
    f[aluf_pkg::Flag5] = r[5];
    return f;
  endfunction

  function automatic logic [7:0] with_szp(logic [7:0] f, logic [7:0] r);
    f[aluf_pkg::FlagS] = r[7];
    f[aluf_pkg::FlagZ] = (r == 8'h00);
    f[aluf_pkg::FlagH] = 1'b0;
    f[aluf_pkg::FlagN] = 1'b0;
    f[aluf_pkg::FlagP] = ~^r;
    return f;
  endfunction

  function automatic logic [7:0] add_bytes(inout logic [7:0] f, input logic [7:0] a,
                                           input logic [7:0] b, input logic c);
    logic [8:0] r;
    logic [4:0] h;
    r = a + b + c;
    h = a[3:0] + b[3:0] + c;
    f[aluf_pkg::FlagN] = 1'b0;
    f[aluf_pkg::FlagS] = r[7];
    f[aluf_pkg::FlagZ] = (r[7:0] == 8'h00);
    f[aluf_pkg::FlagH] = h[4];
    f[aluf_pkg::FlagP] = (a[7] ^ r[7]) & (b[7] ^ r[7]);
    f[aluf_pkg::FlagC] = r[8];
    f = with_x53(f, r[7:0]);
    return r[7:0];
  endfunction

  function automatic logic [7:0] sub_bytes(inout logic [7:0] f, input logic [7:0] a,
                                           input logic [7:0] b, input logic c);
    logic [7:0] r;
    r = a - b - c;
    f[aluf_pkg::FlagN] = 1'b1;
    f[aluf_pkg::FlagS] = r[7];
    f[aluf_pkg::FlagZ] = (r == 8'h00);
    f[aluf_pkg::FlagH] = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + c);
    f[aluf_pkg::FlagP] = (a[7] ^ b[7]) & (a[7] ^ r[7]);
    f[aluf_pkg::FlagC] = {1'b0, a} < ({1'b0, b} + c);
    f = with_x53(f, r);
    return r;
  endfunction

  function automatic aluf_pkg::out_beat_t alu_predict(input aluf_pkg::in_beat_t beat);
    logic [7:0] f, a, b, r8, v, r, corr;
    logic [15:0] aw, bw, res, cnt, ptr;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [4:0] h5;
    logic cin, t, cy;
    aluf_pkg::out_beat_t o;
    f = flag_model;
    aw = beat.operand_a;
    bw = beat.operand_b;
    res = beat.given_result;
    cnt = beat.counter_in;
    ptr = beat.pointer_in;
    a = aw[7:0];
    b = bw[7:0];
    r8 = res[7:0];
    cin = f[aluf_pkg::FlagC];
    v = 8'h00;
    t = 1'b0;
    case (beat.opcode)
      aluf_pkg::OpInc8, aluf_pkg::OpDec8: begin
        f[aluf_pkg::FlagN] = (beat.opcode == aluf_pkg::OpDec8);
        f[aluf_pkg::FlagS] = r8[7];
        f[aluf_pkg::FlagZ] = (r8 == 8'h00);
        f[aluf_pkg::FlagH] = (beat.opcode == aluf_pkg::OpInc8) ? (a[3:0] == 4'hF)
                                                               : (a[3:0] == 4'h0);
        f[aluf_pkg::FlagP] = (a == ((beat.opcode == aluf_pkg::OpInc8) ? aluf_pkg::IncOvfVal
                                                                      : aluf_pkg::DecOvfVal));
        f = with_x53(f, r8);
      end
      aluf_pkg::OpAdd8: v = add_bytes(f, a, b, 1'b0);
      aluf_pkg::OpSub8: v = sub_bytes(f, a, b, 1'b0);
      aluf_pkg::OpAdc8: v = add_bytes(f, a, b, cin);
      aluf_pkg::OpSbc8: v = sub_bytes(f, a, b, cin);
      aluf_pkg::OpCp:   r = sub_bytes(f, a, b, 1'b0);
      aluf_pkg::OpAdd16: begin
        sum13 = aw[11:0] + bw[11:0];
        sum17 = aw + bw;
        f[aluf_pkg::FlagN] = 1'b0;
        f[aluf_pkg::FlagH] = sum13[12];
        f[aluf_pkg::FlagC] = sum17[16];
        f = with_x53(f, res[15:8]);
      end
      aluf_pkg::OpOrXor, aluf_pkg::OpAnd: begin
        f = with_szp(f, a);
        f[aluf_pkg::FlagH] = (beat.opcode == aluf_pkg::OpAnd);
        f[aluf_pkg::FlagC] = 1'b0;
        f = with_x53(f, a);
      end
      aluf_pkg::OpAdc16, aluf_pkg::OpSbc16: begin
        f[aluf_pkg::FlagN] = (beat.opcode == aluf_pkg::OpSbc16);
        f[aluf_pkg::FlagS] = res[15];
        f[aluf_pkg::FlagZ] = (res == 16'h0000);
        if (beat.opcode == aluf_pkg::OpAdc16) begin
          sum13 = aw[11:0] + bw[11:0] + cin;
          sum17 = aw + bw + cin;
          f[aluf_pkg::FlagH] = sum13[12];
          f[aluf_pkg::FlagP] = (aw[15] ^ res[15]) & (bw[15] ^ res[15]);
          f[aluf_pkg::FlagC] = sum17[16];
          f = with_x53(f, res[7:0]);
        end else begin
          f[aluf_pkg::FlagH] = {1'b0, aw[11:0]} < ({1'b0, bw[11:0]} + cin);
          f[aluf_pkg::FlagP] = (aw[15] ^ bw[15]) & (aw[15] ^ res[15]);
          f[aluf_pkg::FlagC] = {1'b0, aw} < ({1'b0, bw} + cin);
          f = with_x53(f, res[15:8]);
        end
      end
      aluf_pkg::OpBlkXfer: begin
        f[aluf_pkg::FlagN] = 1'b0;
        f[aluf_pkg::FlagH] = 1'b0;
        f[aluf_pkg::FlagP] = (cnt != 16'h0000);
        f = with_x53(f, cnt[15:8]);
      end
      aluf_pkg::OpBlkIo: begin
        f[aluf_pkg::FlagZ] = 1'b1;
        f[aluf_pkg::FlagN] = 1'b1;
      end
      aluf_pkg::OpCpd, aluf_pkg::OpCpi: begin
        cnt = cnt - 16'd1;
        ptr = (beat.opcode == aluf_pkg::OpCpi) ? ptr + 16'd1 : ptr - 16'd1;
        r = a - b;
        f[aluf_pkg::FlagS] = r[7];
        f[aluf_pkg::FlagZ] = (r == 8'h00);
        f[aluf_pkg::FlagH] = a[3:0] < b[3:0];
        f[aluf_pkg::FlagP] = (cnt != 16'h0000);
        f[aluf_pkg::FlagN] = 1'b1;
        v = r;
      end
      aluf_pkg::OpRlca, aluf_pkg::OpRrca, aluf_pkg::OpRra, aluf_pkg::OpRla: begin
        case (beat.opcode)
          aluf_pkg::OpRlca: begin t = a[7]; v = {a[6:0], t}; end
          aluf_pkg::OpRrca: begin t = a[0]; v = {t, a[7:1]}; end
          aluf_pkg::OpRra:  begin t = a[0]; v = {cin, a[7:1]}; end
          default: begin t = a[7]; v = {a[6:0], cin}; end
        endcase
        f[aluf_pkg::FlagH] = 1'b0;
        f[aluf_pkg::FlagN] = 1'b0;
        f[aluf_pkg::FlagC] = t;
      end
      aluf_pkg::OpBit: begin
        f[aluf_pkg::FlagN] = 1'b0;
        f[aluf_pkg::FlagH] = 1'b1;
        f[aluf_pkg::FlagZ] = ~b[beat.bit_index];
      end
      aluf_pkg::OpRlc, aluf_pkg::OpRl, aluf_pkg::OpRrc, aluf_pkg::OpRr,
      aluf_pkg::OpSla, aluf_pkg::OpSra, aluf_pkg::OpSll, aluf_pkg::OpSrl: begin
        case (beat.opcode)
          aluf_pkg::OpRlc: begin t = b[7]; v = {b[6:0], t}; end
          aluf_pkg::OpRl:  begin t = b[7]; v = {b[6:0], cin}; end
          aluf_pkg::OpRrc: begin t = b[0]; v = {t, b[7:1]}; end
          aluf_pkg::OpRr:  begin t = b[0]; v = {cin, b[7:1]}; end
          aluf_pkg::OpSla: begin t = b[7]; v = {b[6:0], 1'b0}; end
          aluf_pkg::OpSra: begin t = b[0]; v = {b[7], b[7:1]}; end
          aluf_pkg::OpSll: begin t = b[7]; v = {b[6:0], 1'b1}; end
          default: begin t = b[0]; v = {1'b0, b[7:1]}; end
        endcase
        f = with_szp(f, v);
        f[aluf_pkg::FlagC] = t;
      end
      aluf_pkg::OpCpl: begin
        f[aluf_pkg::FlagH] = 1'b1;
        f[aluf_pkg::FlagN] = 1'b1;
        v = ~a;
      end
      aluf_pkg::OpRxd: f = with_szp(f, a);
      aluf_pkg::OpCcf: begin
        f[aluf_pkg::FlagN] = 1'b0;
        f[aluf_pkg::FlagH] = cin;
        f[aluf_pkg::FlagC] = ~cin;
      end
      aluf_pkg::OpScf: begin
        f[aluf_pkg::FlagH] = 1'b0;
        f[aluf_pkg::FlagN] = 1'b0;
        f[aluf_pkg::FlagC] = 1'b1;
      end
      aluf_pkg::OpDaa: begin
        corr = 8'h00;
        cy = 1'b0;
        if (f[aluf_pkg::FlagH] || a[3:0] > aluf_pkg::DaaLoLimit) corr = corr + aluf_pkg::DaaLoAdj;
        if (f[aluf_pkg::FlagC] || a > aluf_pkg::DaaHiLimit) begin
          corr = corr + aluf_pkg::DaaHiAdj;
          cy = 1'b1;
        end
        if (f[aluf_pkg::FlagN]) begin
          v = a - corr;
          f[aluf_pkg::FlagH] = a[3:0] < corr[3:0];
        end else begin
          v = a + corr;
          h5 = a[3:0] + corr[3:0];
          f[aluf_pkg::FlagH] = h5[4];
        end
        f[aluf_pkg::FlagC] = cy;
        f[aluf_pkg::FlagS] = v[7];
        f[aluf_pkg::FlagZ] = (v == 8'h00);
        f[aluf_pkg::FlagP] = ~^v;
      end
      default: ;
    endcase
    flag_model = f;
    o.value_out = v;
    o.flags_out = f;
    o.counter_out = cnt;
    o.pointer_out = ptr;
    return o;
  endfunction

  function automatic aluf_pkg::in_beat_t alu_beat(logic [5:0] op, logic [15:0] a,
                                                  logic [15:0] b, logic [15:0] res,
                                                  logic [2:0] bi, logic [15:0] cnt,
                                                  logic [15:0] ptr);
    aluf_pkg::in_beat_t beat;
    beat.opcode = op;
    beat.operand_a = a;
    beat.operand_b = b;
    beat.given_result = res;
    beat.bit_index = bi;
    beat.counter_in = cnt;
    beat.pointer_in = ptr;
    return beat;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      3: return 16'($urandom_range(0, 2));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic aluf_pkg::in_beat_t random_alu_beat();
    logic [5:0] op;
    if ($urandom_range(0, 19) == 0) op = 6'($urandom_range(OpUnusedLo, OpUnusedHi));
    else op = 6'($urandom_range(aluf_pkg::OpInc8, aluf_pkg::OpDaa));
    return alu_beat(op, pick_word(), pick_word(), pick_word(), 3'($urandom_range(0, 7)),
                    pick_word(), pick_word());
  endfunction

  function automatic logic [7:0] random_bcd();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  task automatic send_alu_beat(input aluf_pkg::in_beat_t beat);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= beat;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic log_mismatch(input string what, input logic [15:0] want,
                              input logic [15:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  task automatic test_each_operation();
    logic [15:0] ext;
    for (int i = aluf_pkg::OpInc8; i <= aluf_pkg::OpDaa; i++) begin
      ext = (i % 2) ? 16'hFFFF : 16'h0000;
      send_alu_beat(alu_beat(6'(i), ext, ~ext, ext, 3'(i), ~ext, ext));
    end
  endtask

  task automatic test_corner_cases();
    send_alu_beat(alu_beat(OpUnusedLo, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 16'h1234, 16'h5678));
    send_alu_beat(alu_beat(OpUnusedHi, 16'h0000, 16'h0000, 16'h0000, 3'd0, 16'hFFFF, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpInc8, 16'h007F, 16'h0000, 16'h0080, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpDec8, 16'h0080, 16'h0000, 16'h007F, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpInc8, 16'hFFFF, 16'h0000, 16'h0000, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpCpi, 16'h0042, 16'h0042, 16'h0000, 3'd0,
                           16'h0001, 16'hFFFF));
    send_alu_beat(alu_beat(aluf_pkg::OpCpd, 16'h0010, 16'h0001, 16'h0000, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpAdc16, 16'h0FFF, 16'h0001, 16'h1028, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpSbc16, 16'h8000, 16'h0001, 16'h7FFF, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpAdd8, 16'h007F, 16'h0001, 16'h0000, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpSub8, 16'h0080, 16'h0001, 16'h0000, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpAdd8, 16'h0009, 16'h0009, 16'h0000, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpDaa, 16'h0012, 16'h0000, 16'h0000, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpSub8, 16'h0010, 16'h0001, 16'h0000, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpDaa, 16'h000F, 16'h0000, 16'h0000, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpScf, 16'h0000, 16'h0000, 16'h0000, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpCcf, 16'h0000, 16'h0000, 16'h0000, 3'd0,
                           16'h0000, 16'h0000));
    send_alu_beat(alu_beat(aluf_pkg::OpBit, 16'h0000, 16'h0080, 16'h0000, 3'd7,
                           16'h0000, 16'h0000));
  endtask

  task automatic test_random_mix(input int unsigned beats);
    logic [7:0] x, y;
    logic [5:0] op;
    for (int unsigned n = 0; n < beats; n++) begin
      if ($urandom_range(0, 5) == 0) begin
        x = random_bcd();
        y = random_bcd();
        op = $urandom_range(0, 1) ? aluf_pkg::OpAdd8 : aluf_pkg::OpSub8;
        send_alu_beat(alu_beat(op, {8'($urandom), x}, {8'($urandom), y}, pick_word(),
                               3'($urandom_range(0, 7)), pick_word(), pick_word()));
        send_alu_beat(alu_beat(aluf_pkg::OpDaa,
                               {8'($urandom), (op == aluf_pkg::OpAdd8) ? x + y : x - y},
                               pick_word(), pick_word(), 3'($urandom_range(0, 7)),
                               pick_word(), pick_word()));
        n++;
      end else begin
        send_alu_beat(random_alu_beat());
      end
    end
  endtask

  task automatic test_result_backpressure();
    hold_request = 1'b1;
    repeat (24) send_alu_beat(random_alu_beat());
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_mix(200);
  endtask

  initial begin
    out_ready_i <= 1'b0;
    forever begin : ready_driver
      int unsigned low_left;
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        low_left = HoldCycles;
      end
      if (low_left > 0) begin
        out_ready_i <= 1'b0;
        low_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) low_left = $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) alu_results_due.push_back(alu_predict(in_beat_i));
  end

  always @(posedge clk_i) begin : result_check
    aluf_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (alu_results_due.size() == 0) begin
        log_mismatch("unexpected beat", 16'h0000, {8'h00, out_beat_o.value_out});
      end else begin
        want = alu_results_due.pop_front();
        if (out_beat_o.value_out !== want.value_out)
          log_mismatch("value_out", {8'h00, want.value_out}, {8'h00, out_beat_o.value_out});
        if (out_beat_o.flags_out !== want.flags_out)
          log_mismatch("flags_out", {8'h00, want.flags_out}, {8'h00, out_beat_o.flags_out});
        if (out_beat_o.counter_out !== want.counter_out)
          log_mismatch("counter_out", want.counter_out, out_beat_o.counter_out);
        if (out_beat_o.pointer_out !== want.pointer_out)
          log_mismatch("pointer_out", want.pointer_out, out_beat_o.pointer_out);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_beat_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_each_operation();
    test_corner_cases();
    test_random_mix(980);
    test_result_backpressure();
    test_back_to_back();
    in_valid_i <= 1'b0;
    while (alu_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
